/* src/sha_pkg.sv */
// package: sha-256 round constants, initial hash values and helper functions
`default_nettype none
package sha_pkg;

  typedef logic [31:0] word_t;

  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam int unsigned LEN_POS = 56;
  localparam logic [9:0] BLOCK_BITS = 10'd512;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    unique case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    unique case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

/* src/sha_ram.sv */
// generic single-port ram with registered read
`default_nettype none
module sha_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* src/sha_round.sv */
// one sha-256 round plus the message schedule step
`default_nettype none
module sha_round
  import sha_pkg::*;
(
  input  wire word_t       v_in [8],
  input  wire word_t       w_in [16],
  input  wire logic [5:0]  t,
  output word_t            v_out [8],
  output word_t            w_out [16]
);
  word_t s1, ch, t1, s0, mj, t2, lo, hi, wt;

  always_comb begin
    // w_in[0] is w[t]; shift window to hold w[t+1..t+16]
    wt = w_in[0];
    s1 = ror(v_in[4], 6) ^ ror(v_in[4], 11) ^ ror(v_in[4], 25);
    ch = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
    t1 = v_in[7] + s1 + ch + round_k(t) + wt;
    s0 = ror(v_in[0], 2) ^ ror(v_in[0], 13) ^ ror(v_in[0], 22);
    mj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
    t2 = s0 + mj;
    v_out[0] = t1 + t2;
    v_out[1] = v_in[0];
    v_out[2] = v_in[1];
    v_out[3] = v_in[2];
    v_out[4] = v_in[3] + t1;
    v_out[5] = v_in[4];
    v_out[6] = v_in[5];
    v_out[7] = v_in[6];
    lo = ror(w_in[1], 7) ^ ror(w_in[1], 18) ^ (w_in[1] >> 3);
    hi = ror(w_in[14], 17) ^ ror(w_in[14], 19) ^ (w_in[14] >> 10);
    for (int i = 0; i < 15; i++) begin
      w_out[i] = w_in[i+1];
    end
    w_out[15] = w_in[0] + lo + w_in[9] + hi;
  end
endmodule
`default_nettype wire

/* src/sha256_stream_hasher_core.sv */
// sha-256 stream hasher top level
// usage: feed a message one byte per input transaction (in_msg_byte with
// in_byte_present); set in_end_of_message on the last transaction, which may
// carry no byte. the digest leaves as eight out_ transactions, word 0 first,
// out_last_word on word 7.
// a plain byte is accepted while the core is idle. the 64th byte of a block
// starts the compression: the block is loaded from the byte ram (64 reads,
// one a cycle, through the registered read), then 64 rounds, one per cycle,
// then the chaining words are folded; input is stalled throughout.
// a final transaction adds padding writes and one or two compressions, then
// the eight digest words are output.
// the block buffer is a 64x8 ram with registered read; input is
// stalled whenever the block is busy.
// reset (synchronous, rst_n low) loads the initial hash values, clears the
// fill count and the length; the ram contents are not cleared.
// a stalled output holds its word until taken; nothing else proceeds then.
`default_nettype none
module sha256_stream_hasher_core
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_msg_byte,
  input  wire logic        in_byte_present,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_RND  = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]  st_r, st_nxt;
  logic [6:0]  fill_r, fill_nxt;
  logic [63:0] len_r, len_nxt;
  logic [63:0] tot_r, tot_nxt;
  logic        fin_r, fin_nxt;    // compression is part of finishing
  logic        last_r, last_nxt;  // this compression ends the message
  logic [6:0]  cnt_r, cnt_nxt;
  word_t       h_r [8];
  word_t       h_nxt [8];
  word_t       v_r [8];
  word_t       v_nxt [8];
  word_t       w_r [16];
  word_t       w_nxt [16];
  word_t       rv [8];
  word_t       rw [16];

  logic        ram_we;
  logic [5:0]  ram_addr;
  logic [7:0]  ram_wdata, ram_rdata;
  logic        rd_pend_r, rd_pend_nxt;

  sha_ram #(.Width(8), .Depth(64)) u_buf (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  sha_round u_round (.v_in(v_r), .w_in(w_r), .t(cnt_r[5:0]), .v_out(rv), .w_out(rw));

  logic acc;
  assign in_stall = (st_r != ST_IDLE);
  assign acc = in_valid && !in_stall;
  assign out_valid = (st_r == ST_OUT);
  assign out_word_index = cnt_r[2:0];
  assign out_last_word = (cnt_r[2:0] == 3'd7);
  assign out_digest_word = h_r[cnt_r[2:0]];

  logic [63:0] tot_now;
  always_comb begin
    tot_now = len_r + {54'd0, fill_r + {6'd0, in_byte_present}, 3'd0};
  end

  always_comb begin
    st_nxt = st_r; fill_nxt = fill_r; len_nxt = len_r; tot_nxt = tot_r;
    fin_nxt = fin_r; last_nxt = last_r; cnt_nxt = cnt_r;
    h_nxt = h_r; v_nxt = v_r; w_nxt = w_r;
    ram_we = 1'b0; ram_addr = fill_r[5:0]; ram_wdata = in_msg_byte;
    rd_pend_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_byte_present) begin
            ram_we = 1'b1;
            fill_nxt = fill_r + 7'd1;
          end
          if (in_end_of_message) begin
            tot_nxt = tot_now;
            fin_nxt = 1'b1;
            if (in_byte_present && fill_r == 7'd63) begin
              // block full: compress it, padding follows in a fresh block
              fill_nxt = 7'd0; len_nxt = len_r + {54'd0, BLOCK_BITS};
              st_nxt = ST_LOAD; cnt_nxt = 7'd0; last_nxt = 1'b0;
            end else begin
              st_nxt = ST_PAD; cnt_nxt = 7'd0;
            end
          end else if (in_byte_present && fill_r == 7'd63) begin
            fill_nxt = 7'd0; len_nxt = len_r + {54'd0, BLOCK_BITS};
            st_nxt = ST_LOAD; cnt_nxt = 7'd0; fin_nxt = 1'b0; last_nxt = 1'b0;
          end
        end
      end
      ST_PAD: begin
        // fill_r: next byte slot; cnt_r==0 writes the marker
        ram_we = 1'b1;
        ram_addr = fill_r[5:0];
        if (cnt_r == 7'd0) begin
          ram_wdata = PAD_MARKER;
        end else if (fill_r[5:0] >= 6'(LEN_POS) && last_r) begin
          ram_wdata = tot_r[8*(7 - (fill_r[5:0] - 6'(LEN_POS))) +: 8];
        end else begin
          ram_wdata = 8'h00;
        end
        cnt_nxt = 7'd1;
        if (cnt_r == 7'd0) begin
          last_nxt = (fill_r[5:0] < 6'd56);
        end
        fill_nxt = fill_r + 7'd1;
        if (fill_r[5:0] == 6'd63) begin
          fill_nxt = 7'd0;
          st_nxt = ST_LOAD; cnt_nxt = 7'd0;
          if (cnt_r == 7'd0) last_nxt = 1'b0;
        end
      end
      ST_LOAD: begin
        // read bytes 0..63; data arrives in the cycle after its read
        ram_addr = cnt_r[5:0];
        rd_pend_nxt = !cnt_r[6];
        if (rd_pend_r) begin
          w_nxt[15] = {w_r[15][23:0], ram_rdata};
          // first byte of a word opens a new slot at the top of the window
          if (cnt_r[1:0] == 2'd1) begin
            for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
            w_nxt[15] = {24'd0, ram_rdata};
          end
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd64) begin
          rd_pend_nxt = 1'b0;
          st_nxt = ST_RND; cnt_nxt = 7'd0;
          v_nxt = h_r;
        end
      end
      ST_RND: begin
        v_nxt = rv; w_nxt = rw;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) st_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) h_nxt[i] = h_r[i] + v_r[i];
        cnt_nxt = 7'd0;
        if (!fin_r) st_nxt = ST_IDLE;
        else if (last_r) st_nxt = ST_OUT;
        else begin
          // second padding block: zeros and length, marker too when the
          // message ended exactly on a block boundary
          st_nxt = ST_PAD; last_nxt = 1'b1; fill_nxt = 7'd0;
          cnt_nxt = (tot_r[8:3] == 6'd0) ? 7'd0 : 7'd1;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r[2:0] == 3'd7) begin
            st_nxt = ST_IDLE; cnt_nxt = 7'd0;
            for (int i = 0; i < 8; i++) h_nxt[i] = init_hash(3'(i));
            fill_nxt = 7'd0; len_nxt = 64'd0; fin_nxt = 1'b0;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; fill_r <= 7'd0; len_r <= 64'd0; fin_r <= 1'b0;
      last_r <= 1'b0; cnt_r <= 7'd0; rd_pend_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_hash(3'(i));
    end else begin
      st_r <= st_nxt; fill_r <= fill_nxt; len_r <= len_nxt; fin_r <= fin_nxt;
      last_r <= last_nxt; cnt_r <= cnt_nxt; rd_pend_r <= rd_pend_nxt;
      h_r <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tot_r <= tot_nxt; v_r <= v_nxt; w_r <= w_nxt;
  end
endmodule
`default_nettype wire

/* src/sha_checker.sv */
// port-level checker for the sha-256 stream hasher
`default_nettype none
module sha_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_digest_word,
  input wire logic [2:0]  out_word_index,
  input wire logic        out_last_word
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word))
    else $error("stalled digest word changed");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last flag mismatch");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=>
      out_valid && out_word_index == $past(out_word_index) + 3'd1)
    else $error("digest words out of order");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while digest pending");
endmodule

bind sha256_stream_hasher_core sha_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_digest_word(out_digest_word),
  .out_word_index(out_word_index), .out_last_word(out_last_word)
);
`default_nettype wire
